// ===== hdl/iuhp_pkg.sv =====
// ----------------------------------------------------------------------------
// iuhp_pkg
// Shared constants, reject codes and record types for the IPv4/UDP header
// parser.
// ----------------------------------------------------------------------------
`default_nettype none

package iuhp_pkg;

	localparam int CNT_W = 17;
	localparam logic [CNT_W-1:0] COUNT_MAX = 17'h1FFFF;

	localparam logic [5:0]  MIN_HEADER  = 6'd20;
	localparam logic [3:0]  UDP_HEADER  = 4'd8;
	localparam logic [7:0]  PROTO_UDP   = 8'd17;
	localparam logic [15:0] FRAG_MASK   = 16'h3FFF;
	localparam logic [3:0]  IP_VERSION4 = 4'd4;
	localparam logic [2:0]  UDP_HDR_BYTES = 3'd6;

	// reject codes
	localparam logic [2:0] RC_OK       = 3'd0;
	localparam logic [2:0] RC_SHORT    = 3'd1;
	localparam logic [2:0] RC_NOT_IPV4 = 3'd2;
	localparam logic [2:0] RC_BAD_IHL  = 3'd3;
	localparam logic [2:0] RC_FRAGMENT = 3'd4;
	localparam logic [2:0] RC_NOT_UDP  = 3'd5;
	localparam logic [2:0] RC_TRUNC    = 3'd6;
	localparam logic [2:0] RC_BAD_ULEN = 3'd7;

	// request queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;
	localparam int QCW    = 3;

	// header snapshot taken on the last byte of a packet
	typedef struct packed {
		logic [CNT_W-1:0] pkt_len;
		logic [3:0]       version;
		logic [3:0]       ihl;
		logic             frag_nz;
		logic             is_udp;
		logic [15:0]      total_length;
		logic [15:0]      ident;
		logic [31:0]      src_addr;
		logic [31:0]      dst_addr;
		logic [15:0]      src_port;
		logic [15:0]      dst_port;
		logic [15:0]      udp_length;
	} pkt_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

// ===== hdl/iuhp_front.sv =====
// ----------------------------------------------------------------------------
// iuhp_front
// Byte capture: counts packet bytes, latches header fields as they pass and
// pushes one header request into the queue on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module iuhp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  iuhp_pkg::q_status_t q_status,
	output logic                push,
	output iuhp_pkg::pkt_rec_t  rec
);
	import iuhp_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [7:0]       vihl_q;
	logic [15:0]      tlen_q;
	logic [15:0]      ident_q;
	logic [15:0]      frag_q;
	logic [7:0]       proto_q;
	logic [31:0]      saddr_q;
	logic [31:0]      daddr_q;
	logic [15:0]      sport_q;
	logic [15:0]      dport_q;
	logic [15:0]      ulen_q;

	logic [CNT_W-1:0] nxt_count;
	logic [7:0]       nxt_vihl;
	logic [15:0]      nxt_tlen;
	logic [15:0]      nxt_ident;
	logic [15:0]      nxt_frag;
	logic [7:0]       nxt_proto;
	logic [31:0]      nxt_saddr;
	logic [31:0]      nxt_daddr;
	logic [15:0]      nxt_sport;
	logic [15:0]      nxt_dport;
	logic [15:0]      nxt_ulen;

	logic             sat;
	logic [5:0]       ihl_b;
	logic [CNT_W-1:0] ihl_ext;
	logic [CNT_W-1:0] rel;
	logic             take;

	assign byte_stall = q_status.full;
	assign take       = byte_valid && !byte_stall;
	assign push       = take && last_byte;

	always_comb begin
		nxt_vihl  = vihl_q;
		nxt_tlen  = tlen_q;
		nxt_ident = ident_q;
		nxt_frag  = frag_q;
		nxt_proto = proto_q;
		nxt_saddr = saddr_q;
		nxt_daddr = daddr_q;
		nxt_sport = sport_q;
		nxt_dport = dport_q;
		nxt_ulen  = ulen_q;
		sat       = (count_q == COUNT_MAX);
		// IHL of the first byte applies to that byte already
		ihl_b     = (count_q == '0) ? {data_byte[3:0], 2'b00} : {vihl_q[3:0], 2'b00};
		ihl_ext   = {{(CNT_W-6){1'b0}}, ihl_b};
		rel       = count_q - ihl_ext;
		if (!sat) begin
			case (count_q) inside
				17'd0:           nxt_vihl  = data_byte;
				17'd2, 17'd3:    nxt_tlen  = {tlen_q[7:0], data_byte};
				17'd4, 17'd5:    nxt_ident = {ident_q[7:0], data_byte};
				17'd6, 17'd7:    nxt_frag  = {frag_q[7:0], data_byte};
				17'd9:           nxt_proto = data_byte;
				[17'd12:17'd15]: nxt_saddr = {saddr_q[23:0], data_byte};
				[17'd16:17'd19]: nxt_daddr = {daddr_q[23:0], data_byte};
				default: ;
			endcase
			if (count_q >= ihl_ext && rel < {{(CNT_W-3){1'b0}}, UDP_HDR_BYTES}) begin
				case (rel[2:0]) inside
					3'd0, 3'd1: nxt_sport = {sport_q[7:0], data_byte};
					3'd2, 3'd3: nxt_dport = {dport_q[7:0], data_byte};
					3'd4, 3'd5: nxt_ulen  = {ulen_q[7:0], data_byte};
					default: ;
				endcase
			end
		end
		nxt_count = sat ? count_q : count_q + 17'd1;
	end

	always_comb begin
		rec.pkt_len      = nxt_count;
		rec.version      = nxt_vihl[7:4];
		rec.ihl          = nxt_vihl[3:0];
		rec.frag_nz      = |(nxt_frag & FRAG_MASK);
		rec.is_udp       = (nxt_proto == PROTO_UDP);
		rec.total_length = nxt_tlen;
		rec.ident        = nxt_ident;
		rec.src_addr     = nxt_saddr;
		rec.dst_addr     = nxt_daddr;
		rec.src_port     = nxt_sport;
		rec.dst_port     = nxt_dport;
		rec.udp_length   = nxt_ulen;
	end

	// all capture state clears once the verdict request is queued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			vihl_q  <= '0;
			tlen_q  <= '0;
			ident_q <= '0;
			frag_q  <= '0;
			proto_q <= '0;
			saddr_q <= '0;
			daddr_q <= '0;
			sport_q <= '0;
			dport_q <= '0;
			ulen_q  <= '0;
		end else if (take) begin
			if (last_byte) begin
				count_q <= '0;
				vihl_q  <= '0;
				tlen_q  <= '0;
				ident_q <= '0;
				frag_q  <= '0;
				proto_q <= '0;
				saddr_q <= '0;
				daddr_q <= '0;
				sport_q <= '0;
				dport_q <= '0;
				ulen_q  <= '0;
			end else begin
				count_q <= nxt_count;
				vihl_q  <= nxt_vihl;
				tlen_q  <= nxt_tlen;
				ident_q <= nxt_ident;
				frag_q  <= nxt_frag;
				proto_q <= nxt_proto;
				saddr_q <= nxt_saddr;
				daddr_q <= nxt_daddr;
				sport_q <= nxt_sport;
				dport_q <= nxt_dport;
				ulen_q  <= nxt_ulen;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/iuhp_queue.sv =====
// ----------------------------------------------------------------------------
// iuhp_queue
// Short request queue of header snapshots between capture and verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module iuhp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  iuhp_pkg::pkt_rec_t  rec_in,
	input  logic                pop,
	output iuhp_pkg::pkt_rec_t  rec_out,
	output iuhp_pkg::q_status_t q_status
);
	import iuhp_pkg::*;

	pkt_rec_t         entry_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   fill_q;
	logic             do_push;
	logic             do_pop;

	assign q_status.full  = (fill_q == QCW'(QDEPTH));
	assign q_status.empty = (fill_q == '0);
	assign do_push = push && !q_status.full;
	assign do_pop  = pop && !q_status.empty;
	assign rec_out = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= rec_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + QCW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - QCW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/iuhp_back.sv =====
// ----------------------------------------------------------------------------
// iuhp_back
// Verdict: runs the header checks in order on the queued snapshot and holds
// the result in an output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module iuhp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  iuhp_pkg::q_status_t q_status,
	input  iuhp_pkg::pkt_rec_t  rec,
	output logic                pop,
	output logic                result_valid,
	input  logic                result_stall,
	output logic                accepted,
	output logic [2:0]          reject_code,
	output logic [15:0]         source_port,
	output logic [15:0]         dest_port,
	output logic [5:0]          header_length,
	output logic [6:0]          payload_start,
	output logic [15:0]         payload_length,
	output logic [31:0]         source_address,
	output logic [31:0]         dest_address,
	output logic [15:0]         ident
);
	import iuhp_pkg::*;

	logic             valid_q;
	logic [2:0]       code;
	logic [5:0]       ihl_b;
	logic [CNT_W-1:0] ihl_ext;
	logic [CNT_W-1:0] ihl_plus_udp;
	logic [CNT_W-1:0] ihl_plus_ulen;

	logic             accepted_q;
	logic [2:0]       code_q;
	logic [15:0]      sport_q;
	logic [15:0]      dport_q;
	logic [5:0]       hlen_q;
	logic [6:0]       poff_q;
	logic [15:0]      plen_q;
	logic [31:0]      saddr_q;
	logic [31:0]      daddr_q;
	logic [15:0]      ident_q;

	assign pop = !q_status.empty && (!valid_q || !result_stall);

	always_comb begin
		ihl_b         = {rec.ihl, 2'b00};
		ihl_ext       = {{(CNT_W-6){1'b0}}, ihl_b};
		ihl_plus_udp  = ihl_ext + {{(CNT_W-4){1'b0}}, UDP_HEADER};
		ihl_plus_ulen = ihl_ext + {1'b0, rec.udp_length};
		if (rec.pkt_len < {{(CNT_W-6){1'b0}}, MIN_HEADER}) begin
			code = RC_SHORT;
		end else if (rec.version != IP_VERSION4) begin
			code = RC_NOT_IPV4;
		end else if (ihl_b < MIN_HEADER || rec.pkt_len < ihl_plus_udp) begin
			code = RC_BAD_IHL;
		end else if (rec.frag_nz) begin
			code = RC_FRAGMENT;
		end else if (!rec.is_udp) begin
			code = RC_NOT_UDP;
		end else if ({1'b0, rec.total_length} > rec.pkt_len) begin
			code = RC_TRUNC;
		end else if (rec.udp_length < {12'd0, UDP_HEADER} || ihl_plus_ulen > rec.pkt_len) begin
			code = RC_BAD_ULEN;
		end else begin
			code = RC_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			code_q     <= code;
			accepted_q <= (code == RC_OK);
			if (code == RC_OK) begin
				sport_q <= rec.src_port;
				dport_q <= rec.dst_port;
				hlen_q  <= ihl_b;
				poff_q  <= {1'b0, ihl_b} + {3'd0, UDP_HEADER};
				plen_q  <= rec.udp_length - {12'd0, UDP_HEADER};
				saddr_q <= rec.src_addr;
				daddr_q <= rec.dst_addr;
				ident_q <= rec.ident;
			end else begin
				sport_q <= '0;
				dport_q <= '0;
				hlen_q  <= '0;
				poff_q  <= '0;
				plen_q  <= '0;
				saddr_q <= '0;
				daddr_q <= '0;
				ident_q <= '0;
			end
		end
	end

	assign result_valid   = valid_q;
	assign accepted       = accepted_q;
	assign reject_code    = code_q;
	assign source_port    = sport_q;
	assign dest_port      = dport_q;
	assign header_length  = hlen_q;
	assign payload_start  = poff_q;
	assign payload_length = plen_q;
	assign source_address = saddr_q;
	assign dest_address   = daddr_q;
	assign ident          = ident_q;

endmodule

`default_nettype wire

// ===== hdl/ipv4_udp_header_parser.sv =====
// ----------------------------------------------------------------------------
// ipv4_udp_header_parser
// Streaming IPv4/UDP header parser with one verdict per packet.
//
// Input channel (byte_valid / byte_stall): one packet byte per request,
// last_byte set on the final byte. A byte is taken when byte_valid is high
// and byte_stall low. One byte per cycle is sustained while byte_stall is low.
// Output channel (result_valid / result_stall): one verdict per packet,
// with accepted, reject_code and the header fields; all fields other than
// the code are zero for a rejected packet.
// The last byte's snapshot goes via the request queue to the output register.
// Throughput: one byte per cycle while byte_stall is low; back to back
// one-byte packets give one verdict per cycle while result_stall is low.
// The four-entry request queue between capture and verdict absorbs output
// stalls; byte_stall rises only when it is full.
// While result_stall is high the output holds its verdict unchanged.
// Reset: arst_n clears the byte counter, captured fields, the queue and the
// output valid; the first byte after reset is byte 0 of a packet.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_udp_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        accepted,
	output logic [2:0]  reject_code,
	output logic [15:0] source_port,
	output logic [15:0] dest_port,
	output logic [5:0]  header_length,
	output logic [6:0]  payload_start,
	output logic [15:0] payload_length,
	output logic [31:0] source_address,
	output logic [31:0] dest_address,
	output logic [15:0] ident
);
	import iuhp_pkg::*;

	q_status_t q_status;
	pkt_rec_t  rec_in;
	pkt_rec_t  rec_head;
	logic      push;
	logic      pop;

	iuhp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.q_status   (q_status),
		.push       (push),
		.rec        (rec_in)
	);

	iuhp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.rec_in   (rec_in),
		.pop      (pop),
		.rec_out  (rec_head),
		.q_status (q_status)
	);

	iuhp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_status       (q_status),
		.rec            (rec_head),
		.pop            (pop),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.accepted       (accepted),
		.reject_code    (reject_code),
		.source_port    (source_port),
		.dest_port      (dest_port),
		.header_length  (header_length),
		.payload_start  (payload_start),
		.payload_length (payload_length),
		.source_address (source_address),
		.dest_address   (dest_address),
		.ident          (ident)
	);

endmodule

`default_nettype wire

// ===== hdl/iuhp_checker.sv =====
// ----------------------------------------------------------------------------
// iuhp_checker
// Port-level checks on the parser's verdict channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module iuhp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic        accepted,
	input logic [2:0]  reject_code,
	input logic [15:0] source_port,
	input logic [15:0] dest_port,
	input logic [5:0]  header_length,
	input logic [6:0]  payload_start,
	input logic [15:0] payload_length,
	input logic [31:0] source_address,
	input logic [31:0] dest_address,
	input logic [15:0] ident
);
	import iuhp_pkg::*;

	// a stalled verdict holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(reject_code)
			&& $stable(source_port) && $stable(payload_length))
		else $error("stalled verdict changed");

	a_acc_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (accepted == (reject_code == RC_OK)))
		else $error("accepted disagrees with reject_code");

	a_rej_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !accepted |-> source_port == '0 && dest_port == '0
			&& header_length == '0 && payload_start == '0 && payload_length == '0
			&& source_address == '0 && dest_address == '0 && ident == '0)
		else $error("rejected verdict carries fields");

	a_offsets: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && accepted |-> header_length >= MIN_HEADER
			&& payload_start == {1'b0, header_length} + {3'd0, UDP_HEADER})
		else $error("header length and payload offset inconsistent");

endmodule

bind ipv4_udp_header_parser iuhp_checker u_iuhp_checker (.*);

`default_nettype wire

// ===== dv/tb_ipv4_udp_header_parser.sv =====
// ----------------------------------------------------------------------------
// tb_ipv4_udp_header_parser
// Self-checking bench for the streaming IPv4/UDP header parser. A table of
// directed packets covers each reject reason and the field extremes. Random
// packets follow, mostly well-formed with random content, the rest corrupted
// or plain noise. Each verdict is checked field by field against a byte-level
// parser model (typed rows: their code), with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_ipv4_udp_header_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import iuhp_pkg::*;

	localparam int RANDOM_BYTES   = 960;
	localparam int RANDOM_PKTS    = 12;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic        acc;
		logic [2:0]  code;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [5:0]  hlen;
		logic [6:0]  poff;
		logic [15:0] plen;
		logic [31:0] saddr;
		logic [31:0] daddr;
		logic [15:0] id;
	} verdict_t;

	typedef struct packed {
		logic [17:0] len;
		logic [7:0]  vihl;
		logic [15:0] tot;
		logic [15:0] frag;
		logic [7:0]  proto;
		logic [15:0] ulen;
		logic        rnd_fill;
		logic [7:0]  fill;
		logic        typed;
		logic [2:0]  code;
	} pkt_spec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic        accepted;
	logic [2:0]  reject_code;
	logic [15:0] source_port;
	logic [15:0] dest_port;
	logic [5:0]  header_length;
	logic [6:0]  payload_start;
	logic [15:0] payload_length;
	logic [31:0] source_address;
	logic [31:0] dest_address;
	logic [15:0] ident;

	logic gaps_on = 1'b1;
	int   errors = 0;
	int   idle_cycles = 0;
	int   rnd_bytes = 0;
	int   rnd_pkts = 0;

	verdict_t   verdict_q [$];
	logic [3:0] tag_q [$];
	pkt_spec_t  dir_rows [$];

	// parser model state
	logic [16:0] p_cnt = '0;
	logic [7:0]  p_vihl = '0;
	logic [15:0] p_tot = '0;
	logic [15:0] p_id = '0;
	logic [15:0] p_frag = '0;
	logic [7:0]  p_proto = '0;
	logic [31:0] p_saddr = '0;
	logic [31:0] p_daddr = '0;
	logic [15:0] p_sport = '0;
	logic [15:0] p_dport = '0;
	logic [15:0] p_ulen = '0;

	ipv4_udp_header_parser DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_valid     (byte_valid),
		.byte_stall     (byte_stall),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.accepted       (accepted),
		.reject_code    (reject_code),
		.source_port    (source_port),
		.dest_port      (dest_port),
		.header_length  (header_length),
		.payload_start  (payload_start),
		.payload_length (payload_length),
		.source_address (source_address),
		.dest_address   (dest_address),
		.ident          (ident)
	);

	always #2 clk = ~clk;

	function automatic logic [2:0] model_code(input int n);
		int hl;
		hl = p_vihl[3:0] * 4;
		if (n < MIN_HEADER)
			return RC_SHORT;
		if (p_vihl[7:4] != IP_VERSION4)
			return RC_NOT_IPV4;
		if (hl < MIN_HEADER || n < hl + UDP_HEADER)
			return RC_BAD_IHL;
		if ((p_frag & FRAG_MASK) != '0)
			return RC_FRAGMENT;
		if (p_proto != PROTO_UDP)
			return RC_NOT_UDP;
		if (p_tot > n)
			return RC_TRUNC;
		if (p_ulen < UDP_HEADER || hl + p_ulen > n)
			return RC_BAD_ULEN;
		return RC_OK;
	endfunction

	task automatic parse_byte(input logic [7:0] b, input logic l,
			output logic done, output verdict_t v);
		int pos;
		int hl;
		pos = int'(p_cnt);
		hl = p_vihl[3:0] * 4;
		done = l;
		v = '0;
		if (p_cnt != COUNT_MAX) begin
			if (pos == 0) begin
				p_vihl = b;
				hl = b[3:0] * 4;
			end else if (pos == 2 || pos == 3)
				p_tot = {p_tot[7:0], b};
			else if (pos == 4 || pos == 5)
				p_id = {p_id[7:0], b};
			else if (pos == 6 || pos == 7)
				p_frag = {p_frag[7:0], b};
			else if (pos == 9)
				p_proto = b;
			else if (pos >= 12 && pos < 16)
				p_saddr = {p_saddr[23:0], b};
			else if (pos >= 16 && pos < 20)
				p_daddr = {p_daddr[23:0], b};
			if (pos == hl || pos == hl + 1)
				p_sport = {p_sport[7:0], b};
			else if (pos == hl + 2 || pos == hl + 3)
				p_dport = {p_dport[7:0], b};
			else if (pos == hl + 4 || pos == hl + 5)
				p_ulen = {p_ulen[7:0], b};
			p_cnt = p_cnt + 17'd1;
		end
		if (l) begin
			v.code = model_code(int'(p_cnt));
			if (v.code == RC_OK) begin
				hl = p_vihl[3:0] * 4;
				v.acc = 1'b1;
				v.sport = p_sport;
				v.dport = p_dport;
				v.hlen = hl[5:0];
				v.poff = 7'(hl + UDP_HEADER);
				v.plen = p_ulen - 16'(UDP_HEADER);
				v.saddr = p_saddr;
				v.daddr = p_daddr;
				v.id = p_id;
			end
			p_cnt = '0;
			p_vihl = '0;
			p_tot = '0;
			p_id = '0;
			p_frag = '0;
			p_proto = '0;
			p_saddr = '0;
			p_daddr = '0;
			p_sport = '0;
			p_dport = '0;
			p_ulen = '0;
		end
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin : scoreboard
		verdict_t   want;
		verdict_t   pred;
		logic       done;
		logic [3:0] tag;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (verdict_q.size() == 0) begin
					errors++;
					$display("%0t: verdict with none expected, actual code %0d",
						$time, reject_code);
				end else begin
					want = verdict_q.pop_front();
					check_field("accepted", want.acc, accepted);
					check_field("reject_code", want.code, reject_code);
					check_field("source_port", want.sport, source_port);
					check_field("dest_port", want.dport, dest_port);
					check_field("header_length", want.hlen, header_length);
					check_field("payload_start", want.poff, payload_start);
					check_field("payload_length", want.plen, payload_length);
					check_field("source_address", want.saddr, source_address);
					check_field("dest_address", want.daddr, dest_address);
					check_field("ident", want.id, ident);
				end
			end
			if (byte_valid && !byte_stall) begin
				parse_byte(data_byte, last_byte, done, pred);
				if (done) begin
					tag = tag_q.pop_front();
					// typed rows: rejected, every field but the code is zero
					if (tag[3]) begin
						pred = '0;
						pred.code = tag[2:0];
					end
					verdict_q.push_back(pred);
				end
			end
		end
	end

	always @(posedge clk)
		result_stall <= gaps_on && ($urandom_range(99) < 18);

	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic send_byte(input logic [7:0] b, input logic l);
		while (gaps_on && $urandom_range(99) < 18) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= b;
		last_byte <= l;
		do
			@(posedge clk);
		while (byte_stall);
	endtask

	// header fields override the UDP length where a small IHL makes them overlap
	function automatic logic [7:0] pkt_byte(input pkt_spec_t s, input int i);
		int hl;
		logic [7:0] b;
		hl = s.vihl[3:0] * 4;
		b = s.rnd_fill ? 8'($urandom_range(255)) : s.fill;
		case (i)
			0: b = s.vihl;
			2: b = s.tot[15:8];
			3: b = s.tot[7:0];
			6: b = s.frag[15:8];
			7: b = s.frag[7:0];
			9: b = s.proto;
			default: begin
				if (i == hl + 4)
					b = s.ulen[15:8];
				else if (i == hl + 5)
					b = s.ulen[7:0];
			end
		endcase
		return b;
	endfunction

	task automatic run_packet(input pkt_spec_t s);
		tag_q.push_back({s.typed, s.code});
		for (int i = 0; i < s.len; i++)
			send_byte(pkt_byte(s, i), i == s.len - 1);
	endtask

	function automatic pkt_spec_t random_spec();
		pkt_spec_t s;
		int hl;
		s = '0;
		s.rnd_fill = 1'b1;
		s.vihl = {IP_VERSION4, 4'($urandom_range(15, 5))};
		hl = s.vihl[3:0] * 4;
		s.ulen = 16'($urandom_range(24, 8));
		s.len = 18'(hl + s.ulen + $urandom_range(8, 0));
		s.tot = $urandom_range(1) ? 16'(s.len) : 16'($urandom_range(s.len, 0));
		s.frag = {2'($urandom_range(3)), 14'd0};
		s.proto = PROTO_UDP;
		case ($urandom_range(19))
			0: s.vihl[7:4] = 4'($urandom_range(15));
			1: s.vihl[3:0] = 4'($urandom_range(4));
			2: s.frag[13:0] = 14'($urandom_range(16383));
			3: s.proto = 8'($urandom_range(255));
			4: s.tot = 16'($urandom_range(65535, s.len + 1));
			5: s.ulen = 16'($urandom_range(65535));
			6: s.len = 18'($urandom_range(s.len, 1));
			7: begin
				s.len = 18'($urandom_range(40, 1));
				s.vihl = 8'($urandom_range(255));
				s.tot = 16'($urandom_range(65535));
				s.frag = 16'($urandom_range(65535));
				s.proto = 8'($urandom_range(255));
				s.ulen = 16'($urandom_range(65535));
			end
			default: ;
		endcase
		return s;
	endfunction

	initial begin
		dir_rows = '{
			'{1, 8'h45, 0, 0, PROTO_UDP, 8, 0, 8'h00, 1, RC_SHORT},
			'{19, 8'h45, 19, 0, PROTO_UDP, 8, 0, 8'hFF, 1, RC_SHORT},
			'{20, 8'h65, 20, 0, PROTO_UDP, 8, 1, 8'h00, 1, RC_NOT_IPV4},
			'{40, 8'hFF, 40, 0, PROTO_UDP, 8, 0, 8'hFF, 1, RC_NOT_IPV4},
			'{40, 8'h44, 40, 0, PROTO_UDP, 8, 1, 8'h00, 1, RC_BAD_IHL},
			'{40, 8'h40, 40, 0, PROTO_UDP, 8, 1, 8'h00, 1, RC_BAD_IHL},
			'{27, 8'h45, 27, 0, PROTO_UDP, 8, 1, 8'h00, 1, RC_BAD_IHL},
			'{48, 8'h45, 48, 16'h0001, 8'd6, 8, 1, 8'h00, 1, RC_FRAGMENT},
			'{48, 8'h45, 48, 16'h2000, PROTO_UDP, 8, 1, 8'h00, 1, RC_FRAGMENT},
			'{48, 8'h45, 48, 16'hFFFF, PROTO_UDP, 8, 0, 8'h00, 1, RC_FRAGMENT},
			'{48, 8'h45, 48, 16'h4000, PROTO_UDP, 28, 1, 8'h00, 0, RC_OK},
			'{48, 8'h45, 48, 0, 8'd6, 28, 1, 8'h00, 1, RC_NOT_UDP},
			'{48, 8'h45, 49, 0, PROTO_UDP, 7, 1, 8'h00, 1, RC_TRUNC},
			'{48, 8'h45, 48, 0, PROTO_UDP, 7, 1, 8'h00, 1, RC_BAD_ULEN},
			'{48, 8'h45, 48, 0, PROTO_UDP, 29, 1, 8'h00, 1, RC_BAD_ULEN},
			'{48, 8'h45, 48, 0, PROTO_UDP, 16'hFFFF, 1, 8'h00, 1, RC_BAD_ULEN},
			'{48, 8'h45, 0, 0, PROTO_UDP, 28, 1, 8'h00, 0, RC_OK},
			'{28, 8'h45, 28, 0, PROTO_UDP, 8, 0, 8'h00, 0, RC_OK},
			'{68, 8'h4F, 68, 16'hC000, PROTO_UDP, 8, 0, 8'hFF, 0, RC_OK},
			'{28, 8'h45, 28, 0, PROTO_UDP, 8, 1, 8'h00, 0, RC_OK}
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[k])
			run_packet(dir_rows[k]);
		while (rnd_bytes < RANDOM_BYTES || rnd_pkts < RANDOM_PKTS) begin
			if (rnd_pkts == 4) begin
				// hold off new requests until the output side has drained
				byte_valid <= 1'b0;
				@(posedge clk);
				wait (verdict_q.size() == 0);
				@(posedge clk);
			end
			gaps_on <= !(rnd_pkts >= 6 && rnd_pkts < 12);
			begin : one_packet
				pkt_spec_t s;
				s = random_spec();
				run_packet(s);
				rnd_bytes += s.len;
			end
			rnd_pkts++;
		end
		byte_valid <= 1'b0;
		@(posedge clk);
		wait (verdict_q.size() == 0);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/iuhp_pkg.sv
hdl/iuhp_front.sv
hdl/iuhp_queue.sv
hdl/iuhp_back.sv
hdl/ipv4_udp_header_parser.sv
hdl/iuhp_checker.sv
dv/tb_ipv4_udp_header_parser.sv
